>>> rtl/core/sswd_pkg.sv
// Shared types, constants and helpers for the slider swipe gesture detector.
// No dependencies; imported by the register block, the gesture engine and the top level.
package sswd_pkg;

	// register map (index into the register list)
	localparam logic [0:0] REG_TIME_LIMIT_SEL = 1'b0;

	// sector thresholds on the slider position
	localparam logic [7:0] POS_SECT4 = 8'd118;
	localparam logic [7:0] POS_SECT3 = 8'd80;
	localparam logic [7:0] POS_SECT2 = 8'd5;

	localparam logic [2:0] SECT_NONE = 3'd0;
	localparam logic [2:0] SECT_1    = 3'd1;
	localparam logic [2:0] SECT_2    = 3'd2;
	localparam logic [2:0] SECT_3    = 3'd3;
	localparam logic [2:0] SECT_4    = 3'd4;

	// time limit select codes
	localparam logic [1:0] TL_1000 = 2'd0;
	localparam logic [1:0] TL_500  = 2'd1;
	localparam logic [1:0] TL_200  = 2'd2;

	// swipe window, already doubled
	localparam logic [31:0] WIN_1000 = 32'd2000;
	localparam logic [31:0] WIN_500  = 32'd1000;
	localparam logic [31:0] WIN_200  = 32'd400;

	localparam logic [31:0] GREEN_HOLD_TICKS = 32'd6000;
	localparam logic [8:0]  GREEN_DUTY_ON    = 9'd350;
	localparam logic [8:0]  GREEN_DUTY_OFF   = 9'd0;

	// move count values of interest
	localparam logic signed [2:0] CNT_ZERO    = 3'sb000;
	localparam logic signed [2:0] CNT_ONE     = 3'sb001;
	localparam logic signed [2:0] CNT_NEG_ONE = 3'sb111;
	localparam logic signed [2:0] CNT_RIGHT   = 3'sb011;
	localparam logic signed [2:0] CNT_LEFT    = 3'sb101;

	typedef struct packed {
		logic        finger_present;
		logic [7:0]  touch_pos;
		logic [31:0] now_tick;
	} sample_t;

	typedef struct packed {
		logic              [2:0] sector;
		logic                    sector_changed;
		logic                    swipe_right;
		logic                    swipe_left;
		logic                    blue_led;
		logic                    green_led;
		logic              [8:0] green_duty;
		logic signed       [2:0] swipe_progress;
	} result_t;

	function automatic logic [2:0] quantize(input logic finger, input logic [7:0] pos);
		logic [2:0] s;
		if (!finger)
			s = SECT_NONE;
		else if (pos > POS_SECT4)
			s = SECT_4;
		else if (pos > POS_SECT3)
			s = SECT_3;
		else if (pos > POS_SECT2)
			s = SECT_2;
		else
			s = SECT_1;
		return s;
	endfunction

	function automatic logic [31:0] window_ticks(input logic [1:0] sel);
		logic [31:0] w;
		case (sel)
			TL_500:  w = WIN_500;
			TL_200:  w = WIN_200;
			TL_1000: w = WIN_1000;
			default: w = WIN_1000;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/sswd_apb_regs.sv
// APB-style configuration register block: holds the swipe time limit select.
// Depends on sswd_pkg for the register map.
module sswd_apb_regs
	import sswd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [1:0]  time_limit_sel
);

	logic        hit;
	logic [1:0]  sel_q;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_TIME_LIMIT_SEL) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= TL_1000;
		end else if (psel && penable && pwrite && pready && hit) begin
			sel_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (hit)
			prdata = {30'd0, sel_q};
	end

	assign time_limit_sel = sel_q;

endmodule

>>> rtl/core/sswd_gesture.sv
// Gesture engine: sector quantizer, move counter, swipe window and LED hold state.
// Depends on sswd_pkg; state advances when upd_en is high.
module sswd_gesture
	import sswd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd_en,
	input  sample_t    sample,
	input  logic [1:0] time_limit_sel,
	output result_t    result
);

	logic signed [2:0] move_q;
	logic        [2:0] last_q;
	logic       [31:0] swipe_start_q;
	logic       [31:0] led_start_q;
	logic              green_q;
	logic              blue_q;

	logic        [2:0] sector;
	logic              changed, up, down, right, left;
	logic signed [2:0] cnt;
	logic       [31:0] swipe_start_n, led_start_n;
	logic              green_n, blue_n;
	logic       [31:0] now;

	always_comb begin
		now     = sample.now_tick;
		sector  = quantize(sample.finger_present, sample.touch_pos);
		changed = (sector != last_q);
		up      = (sector != SECT_NONE) && ({1'b0, sector} == ({1'b0, last_q} + 4'd1));
		down    = (sector != SECT_NONE) && (({1'b0, sector} + 4'd1) == {1'b0, last_q});

		cnt           = move_q;
		swipe_start_n = swipe_start_q;
		led_start_n   = led_start_q;
		green_n       = green_q;
		blue_n        = blue_q;
		right         = 1'b0;
		left          = 1'b0;

		if (changed) begin
			if (up)
				cnt = move_q + 3'sd1;
			else if (down)
				cnt = move_q - 3'sd1;
			else
				cnt = CNT_ZERO;

			if (cnt == CNT_ONE || cnt == CNT_NEG_ONE)
				swipe_start_n = now;

			if (cnt == CNT_RIGHT) begin
				right = 1'b1;
				cnt   = CNT_ZERO;
			end else if (cnt == CNT_LEFT) begin
				left   = 1'b1;
				blue_n = ~blue_q;
				cnt    = CNT_ZERO;
			end

			if (right) begin
				led_start_n = now;
				green_n     = 1'b1;
			end
		end

		// window check runs on every sample
		if ((now - swipe_start_n) > window_ticks(time_limit_sel))
			cnt = CNT_ZERO;

		if (green_n && ((now - led_start_n) > GREEN_HOLD_TICKS))
			green_n = 1'b0;

		result.sector         = sector;
		result.sector_changed = changed;
		result.swipe_right    = right;
		result.swipe_left     = left;
		result.blue_led       = blue_n;
		result.green_led      = green_n;
		result.green_duty     = green_n ? GREEN_DUTY_ON : GREEN_DUTY_OFF;
		result.swipe_progress = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_q        <= CNT_ZERO;
			last_q        <= SECT_NONE;
			swipe_start_q <= 32'd0;
			led_start_q   <= 32'd0;
			green_q       <= 1'b0;
			blue_q        <= 1'b0;
		end else if (upd_en) begin
			move_q        <= cnt;
			last_q        <= sector;
			swipe_start_q <= swipe_start_n;
			led_start_q   <= led_start_n;
			green_q       <= green_n;
			blue_q        <= blue_n;
		end
	end

endmodule

>>> rtl/core/slider_swipe_gesture_detector_unit.sv
// Top level of the slider swipe gesture detector: input register, gesture engine, result register.
// Depends on sswd_pkg, sswd_apb_regs and sswd_gesture.
//
// One slider sample per request on the s_axis side gives one result request on the m_axis
// side. A sample is taken into the input register; when it moves on, the gesture engine
// commits its state at the same edge that loads the result register, which drives
// m_tvalid. The block sustains one sample per clock while m_tready does not stall the
// result register. Stalls on m_tready hold the result register; the input register
// still takes one more sample while a result waits. All tick differences wrap modulo
// 2^32. The time limit select register sits at byte address 0 of the APB-style port
// and should be written only while no sample is in flight.
module slider_swipe_gesture_detector_unit
	import sswd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] finger_present, [8:1] touch_pos, [40:9] now_tick, [47:41] zero
	input  logic [47:0] s_tdata,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] sector, [3] sector_changed, [4] swipe_right, [5] swipe_left,
	// [6] blue_led, [7] green_led, [16:8] green_duty, [19:17] swipe_progress, [23:20] zero
	output logic [23:0] m_tdata
);

	logic       [1:0] time_limit_sel;
	logic             valid_s1, valid_s2;
	sample_t          sample_s1;
	result_t          res_comb, result_s2;
	logic             advance;

	sswd_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.time_limit_sel (time_limit_sel)
	);

	// result register free, or being drained this cycle
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.finger_present <= s_tdata[0];
			sample_s1.touch_pos      <= s_tdata[8:1];
			sample_s1.now_tick       <= s_tdata[40:9];
		end
	end

	// engine state commits only when the sample moves into the result register
	sswd_gesture u_gesture (
		.clk            (clk),
		.arst_n         (arst_n),
		.upd_en         (valid_s1 && advance),
		.sample         (sample_s1),
		.time_limit_sel (time_limit_sel),
		.result         (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_s2 <= res_comb;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0,
		result_s2.swipe_progress,
		result_s2.green_duty,
		result_s2.green_led,
		result_s2.blue_led,
		result_s2.swipe_left,
		result_s2.swipe_right,
		result_s2.sector_changed,
		result_s2.sector};

endmodule

>>> rtl/core/sswd_checker.sv
// Port-level checks on the result stream of the slider swipe gesture detector.
// Bound to slider_swipe_gesture_detector_unit; uses its port names only.
module sswd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// duty follows the green enable
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7] ? (m_tdata[16:8] == 9'd350) : (m_tdata[16:8] == 9'd0)))
		else $error("green duty does not match enable");

	// a swipe needs a sector change and leaves the count cleared
	a_swipe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4] || m_tdata[5]) |->
			m_tdata[3] && !(m_tdata[4] && m_tdata[5]) && (m_tdata[19:17] == 3'd0))
		else $error("bad swipe result");

	// a right swipe always lights green
	a_green: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[7])
		else $error("right swipe without green led");

	// sector in range, count within two
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'd4) &&
			(m_tdata[19:17] != 3'b011) && (m_tdata[19:17] != 3'b100) &&
			(m_tdata[19:17] != 3'b101))
		else $error("sector or progress out of range");

endmodule

bind slider_swipe_gesture_detector_unit sswd_checker u_sswd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
